>>> sv/rwc_pkg.sv
// Shared widths, codes, state type and control structs for the risk convolution block.
`default_nettype none
package rwc_pkg;

    localparam int RWC_MAX_TAPS = 64;
    localparam int VAL_W        = 16;
    localparam int WL_W         = 7;
    localparam int IDX_W        = 6;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b1;

    localparam logic [WL_W-1:0] WL_RESET = 7'd64;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_COMB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic hvalid;
        logic comb;
        logic finish;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_mac_stat;

endpackage
`default_nettype wire

>>> sv/rwc_item_if.sv
// Input channel carrying one command item.
`default_nettype none
interface rwc_item_if
    import rwc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  weight_index;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output mode, output weight_index, output value,
                    input ready);
    modport sink   (input valid, input mode, input weight_index, input value,
                    output ready);
endinterface
`default_nettype wire

>>> sv/rwc_result_if.sv
// Output channel carrying one combined probability result.
`default_nettype none
interface rwc_result_if
    import rwc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] probability;
    logic             saturated;

    modport source (output valid, output probability, output saturated, input ready);
    modport sink   (input valid, input probability, input saturated, output ready);
endinterface
`default_nettype wire

>>> sv/rwc_store.sv
// Weight table and circular sample history memories with registered reads.
`default_nettype none
module rwc_store
    import rwc_pkg::*;
#(
    parameter int MAX_TAPS = RWC_MAX_TAPS
) (
    input  wire                                       i_clk,
    input  wire                                       i_w_we,
    input  wire  [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_w_wa,
    input  wire  [VAL_W-1:0]                          i_w_wd,
    input  wire  [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_w_ra,
    input  wire                                       i_h_we,
    input  wire  [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_h_wa,
    input  wire  [VAL_W-1:0]                          i_h_wd,
    input  wire  [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] i_h_ra,
    output logic [VAL_W-1:0]                          o_w_rd,
    output logic [VAL_W-1:0]                          o_h_rd
);

    logic [VAL_W-1:0] r_wmem [MAX_TAPS];
    logic [VAL_W-1:0] r_hmem [MAX_TAPS];

    always_ff @(posedge i_clk) begin
        if (i_w_we) begin
            r_wmem[i_w_wa] <= i_w_wd;
        end
        o_w_rd <= r_wmem[i_w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_h_we) begin
            r_hmem[i_h_wa] <= i_h_wd;
        end
        o_h_rd <= r_hmem[i_h_ra];
    end

endmodule
`default_nettype wire

>>> sv/rwc_mac.sv
// Shared multiply-accumulate pipeline, baseline combination and output register.
`default_nettype none
module rwc_mac
    import rwc_pkg::*;
#(
    parameter int MAX_TAPS = RWC_MAX_TAPS
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire  t_mac_ctl   i_ctl,
    input  wire  [VAL_W-1:0] i_w_rd,
    input  wire  [VAL_W-1:0] i_h_rd,
    input  wire  [VAL_W-1:0] i_bp,
    output t_mac_stat        o_stat,
    rwc_result_if.source     o_result
);

    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int SW = 2 * VAL_W + CW;

    logic                 r_v1;
    logic                 r_hv1;
    logic                 r_v2;
    logic [2*VAL_W-1:0]   r_prod;
    logic [SW-1:0]        r_acc;
    logic [2*VAL_W+1:0]   r_cprod;
    logic                 r_csat;
    logic                 r_ov;
    logic [VAL_W-1:0]     r_prob;
    logic                 r_osat;

    logic                 sum_sat;
    logic [VAL_W-1:0]     acc16;
    logic [VAL_W:0]       one_m_acc;
    logic [VAL_W:0]       one_m_bp;
    logic [VAL_W:0]       comb_hi;
    logic [VAL_W:0]       prob17;
    logic [VAL_W-1:0]     prob16;

    // Read data from the store arrives in the cycle after the address, so the
    // issue flags are delayed by one stage to line up with it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hv1  <= i_ctl.hvalid;
        r_prod <= r_hv1 ? (i_w_rd * i_h_rd) : '0;
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + SW'(r_prod);
        end
    end

    assign sum_sat   = |r_acc[SW-1:2*VAL_W];
    assign acc16     = sum_sat ? {VAL_W{1'b1}} : r_acc[2*VAL_W-1:VAL_W];
    assign one_m_acc = {1'b1, {VAL_W{1'b0}}} - {1'b0, acc16};
    assign one_m_bp  = {1'b1, {VAL_W{1'b0}}} - {1'b0, i_bp};

    always_ff @(posedge i_clk) begin
        if (i_ctl.comb) begin
            r_cprod <= one_m_acc * one_m_bp;
            r_csat  <= sum_sat;
        end
    end

    assign comb_hi = r_cprod[2*VAL_W:VAL_W];
    assign prob17  = {1'b1, {VAL_W{1'b0}}} - comb_hi;
    assign prob16  = prob17[VAL_W] ? {VAL_W{1'b1}} : prob17[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_ctl.finish) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_prob <= prob16;
            r_osat <= r_csat;
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.probability = r_prob;
    assign o_result.saturated   = r_osat;

    assign o_stat.busy     = r_v1 | r_v2;
    assign o_stat.out_free = !r_ov || o_result.ready;

endmodule
`default_nettype wire

>>> sv/rwc_seq.sv
// Sequencer: item decode, tap sweep, history pointer and fill count, weight clearing pass.
`default_nettype none
module rwc_seq
    import rwc_pkg::*;
#(
    parameter int MAX_TAPS = RWC_MAX_TAPS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    rwc_item_if.sink          i_item,
    input  wire  [WL_W-1:0]   i_wl,
    input  wire  t_mac_stat   i_stat,
    output t_mac_ctl          o_ctl,
    output logic              o_w_we,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_w_wa,
    output logic [VAL_W-1:0]  o_w_wd,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_w_ra,
    output logic              o_h_we,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_h_wa,
    output logic [VAL_W-1:0]  o_h_wd,
    output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] o_h_ra
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(MAX_TAPS);

    t_state          r_state;
    t_state          n_state;
    logic [AW-1:0]   r_k;
    logic [CW-1:0]   r_h;
    logic [AW-1:0]   r_ha;
    logic [AW-1:0]   r_wp;
    logic [CW-1:0]   r_fill;
    logic [AW-1:0]   r_clr;
    logic [VAL_W-1:0] r_val;

    logic            accept;
    logic            is_load;
    logic            is_sample;
    logic            is_clear;
    logic            idx_ok;
    logic [CW-1:0]   taps;
    logic [CW:0]     pm1_x;
    logic [CW:0]     wp_x;
    logic [CW:0]     start_x;
    logic [AW-1:0]   wp_next;
    logic [AW-1:0]   ha_next;

    assign accept    = i_item.valid && i_item.ready;
    assign is_load   = (i_item.mode == MODE_LOAD);
    assign is_sample = (i_item.mode == MODE_SAMPLE);
    assign is_clear  = (i_item.mode == MODE_CLEAR);
    assign idx_ok    = (32'(i_item.weight_index) < MAX_TAPS);
    assign taps      = (32'(i_wl) > MAX_TAPS) ? CW'(MAX_TAPS) : CW'(i_wl);

    // Oldest history slot of the window: p-1 places behind the newest, wrapping.
    assign pm1_x   = (CW + 1)'(taps) - 1'b1;
    assign wp_x    = (CW + 1)'(r_wp);
    assign start_x = (wp_x >= pm1_x) ? (wp_x - pm1_x) : (wp_x + DEPTH_X - pm1_x);

    assign wp_next = (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
    assign ha_next = (r_ha == LAST_ADDR) ? '0 : r_ha + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ctl        = '0;
        i_item.ready = 1'b0;
        o_w_we       = 1'b0;
        o_w_wa       = r_clr;
        o_w_wd       = '0;
        o_h_we       = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_w_we = 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_item.ready = 1'b1;
                if (i_item.valid) begin
                    if (is_load && idx_ok) begin
                        o_w_we = 1'b1;
                        o_w_wa = AW'(i_item.weight_index);
                        o_w_wd = i_item.value;
                    end
                    if (is_sample) begin
                        o_ctl.clear = 1'b1;
                        n_state = (taps == '0) ? S_DRAIN : S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_ctl.issue  = 1'b1;
                o_ctl.hvalid = (r_h < r_fill);
                if (r_h == '0) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_COMB;
                end
            end
            S_COMB: begin
                o_ctl.comb = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.finish = 1'b1;
                    o_h_we = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_w_ra = r_k;
    assign o_h_ra = r_ha;
    assign o_h_wa = wp_next;
    assign o_h_wd = r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_wp   <= '0;
            r_fill <= '0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept && is_clear) begin
                r_fill <= '0;
            end else if (o_h_we) begin
                r_wp <= wp_next;
                if (32'(r_fill) < MAX_TAPS) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            r_k   <= '0;
            r_h   <= taps - 1'b1;
            r_ha  <= AW'(start_x);
            r_val <= i_item.value;
        end else if (r_state == S_RUN) begin
            r_k  <= r_k + 1'b1;
            r_h  <= r_h - 1'b1;
            r_ha <= ha_next;
        end
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |-> i_stat.out_free)
        else $error("result loaded while the output register was occupied");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_TAPS)
        else $error("history fill count beyond table depth");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_sample) |=> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("sample transfer did not start a sweep");

    a_no_issue_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> !o_ctl.issue && !o_h_we)
        else $error("memory activity while draining the pipeline");

    a_hist_write_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_h_we |-> !i_stat.busy)
        else $error("history written while products still in flight");

endmodule
`default_nettype wire

>>> sv/windowed_risk_convolution.sv
// Top level of the windowed risk convolution block with its configuration registers.
//
// Usage: command items arrive on i_item (valid/ready). Mode 0 stores a weight,
// mode 2 forgets the sample history, mode 1 presents a risk sample, and mode 3
// does nothing. Only a sample gives a result, which leaves on o_result
// (valid/ready) as the combined probability and a saturation flag.
// Weight loads, history clears and unused modes are taken in the idle state,
// so they can be sent back to back. A sample starts a sweep over P taps, where
// P is the window length clamped to MAX_TAPS; the products then drain, are
// combined with the baseline, and the result is loaded into the output
// register before the next item is taken; an empty window skips the sweep.
// The single shared multiply-accumulate steps through one tap per cycle, with
// the memory read, product, accumulate and combination stages behind it.
// The output register lets the next item be taken while a result waits; if the
// receiver stalls, a following sample completes its sweep and then holds until
// the earlier result has been transferred.
// After reset the weight table is zeroed by a clearing pass over every address,
// during which no item is taken; configuration writes are accepted throughout.
// The history is cleared at once by a fill count rather than by a sweep.
// Configuration must only be written while no sample is in progress.
`default_nettype none
module windowed_risk_convolution
    import rwc_pkg::*;
#(
    parameter int MAX_TAPS = RWC_MAX_TAPS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    rwc_item_if.sink              i_item,
    rwc_result_if.source          o_result,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [VAL_W-1:0]      i_cfg_data
);

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    logic [VAL_W-1:0] r_bp;
    logic [WL_W-1:0]  r_wl;

    t_mac_ctl         ctl;
    t_mac_stat        stat;
    logic             w_we;
    logic [AW-1:0]    w_wa;
    logic [VAL_W-1:0] w_wd;
    logic [AW-1:0]    w_ra;
    logic             h_we;
    logic [AW-1:0]    h_wa;
    logic [VAL_W-1:0] h_wd;
    logic [AW-1:0]    h_ra;
    logic [VAL_W-1:0] w_rd;
    logic [VAL_W-1:0] h_rd;

    // Baseline probability and window length; a write lands on the next edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp <= '0;
            r_wl <= WL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASELINE: r_bp <= i_cfg_data;
                CFG_WINDOW:   r_wl <= i_cfg_data[WL_W-1:0];
                default:      r_bp <= r_bp;
            endcase
        end
    end

    // The sequencer owns all memory addressing. History writes only happen
    // once every read of the sweep has retired, so no forwarding is needed.
    rwc_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_wl    (r_wl),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_w_we  (w_we),
        .o_w_wa  (w_wa),
        .o_w_wd  (w_wd),
        .o_w_ra  (w_ra),
        .o_h_we  (h_we),
        .o_h_wa  (h_wa),
        .o_h_wd  (h_wd),
        .o_h_ra  (h_ra)
    );

    rwc_store #(
        .MAX_TAPS (MAX_TAPS)
    ) u_store (
        .i_clk  (i_clk),
        .i_w_we (w_we),
        .i_w_wa (w_wa),
        .i_w_wd (w_wd),
        .i_w_ra (w_ra),
        .i_h_we (h_we),
        .i_h_wa (h_wa),
        .i_h_wd (h_wd),
        .i_h_ra (h_ra),
        .o_w_rd (w_rd),
        .o_h_rd (h_rd)
    );

    rwc_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_w_rd   (w_rd),
        .i_h_rd   (h_rd),
        .i_bp     (r_bp),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
